@@ hw/rtl/bounded_integer_set_table_defines.svh @@
// Assertion macros shared by the set table RTL.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef BOUNDED_INTEGER_SET_TABLE_DEFINES_SVH
`define BOUNDED_INTEGER_SET_TABLE_DEFINES_SVH

// Same-cycle implication, off during reset
`define BIST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset
`define BIST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/bist_pkg.sv @@
// Shared types and codes for the bounded integer set table.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package bist_pkg;

   localparam int BIST_CAPACITY = 64;

   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;

   // Broadcast to every cell when a request transfers
   typedef struct packed {
      logic                     capture;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]         position;
   } bist_cap_type;

   // Broadcast to every cell when a request commits
   typedef struct packed {
      logic                     ins;
      logic                     rem;
      logic signed [VALUE_W-1:0] value;
   } bist_upd_type;

endpackage

@@ hw/rtl/bist_if.sv @@
// Valid/ready channel interfaces for requests and responses of the set table.
// Depends on bist_pkg for field widths.
`timescale 1ns / 1ps

interface bist_req_if import bist_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          position;

   modport source (output valid, kind, value, position, input ready);
   modport sink   (input valid, kind, value, position, output ready);
endinterface

interface bist_rsp_if import bist_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      success;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] read_value;
   logic [COUNT_W-1:0]        count;
   logic                      empty_res;

   modport source (output valid, success, status, read_value, count, empty_res,
                   input ready);
   modport sink   (input valid, success, status, read_value, count, empty_res,
                   output ready);
endinterface

@@ hw/rtl/bist_cell.sv @@
// One table cell: holds one entry, compares it with the request, shifts down on remove.
// Depends on bist_pkg.
`timescale 1ns / 1ps

module bist_cell import bist_pkg::*; #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                      clock,
   input  bist_cap_type              cap,
   input  bist_upd_type              upd,
   input  logic [CNT_W-1:0]          count,
   input  logic                      shift_en,
   input  logic signed [VALUE_W-1:0] next_data,
   output logic signed [VALUE_W-1:0] data,
   output logic                      match,
   output logic                      rsel,
   output logic signed [VALUE_W-1:0] rd_gated
);

   logic signed [VALUE_W-1:0] data_ff, data_in;
   logic                      match_ff, match_in;
   logic                      rsel_ff, rsel_in;
   logic                      live;

   // Entry is live while its place lies below the count
   assign live = count > CNT_W'(INDEX);

   // Compare on transfer; hold until the request commits
   always_comb begin
      match_in = match_ff;
      rsel_in  = rsel_ff;
      if (cap.capture) begin
         match_in = live && (data_ff == cap.value);
         rsel_in  = live && (32'(cap.position) == 32'(INDEX));
      end
   end

   // Load on append at the tail, take neighbor on remove
   always_comb begin
      data_in = data_ff;
      if (upd.ins && (count == CNT_W'(INDEX))) begin
         data_in = upd.value;
      end else if (upd.rem && shift_en) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      match_ff <= match_in;
      rsel_ff  <= rsel_in;
   end

   assign data     = data_ff;
   assign match    = match_ff;
   assign rsel     = rsel_ff;
   assign rd_gated = rsel_ff ? data_ff : '0;

endmodule

@@ hw/rtl/bounded_integer_set_table.sv @@
// Flow: a request transfers, the cells compare it, then it commits and the response is
// registered; commit waits while an earlier response is still unaccepted. One request is in
// flight at a time; a finished response may wait while the next request transfers.
// Reset (synchronous, active high) empties the table; entry contents stay undefined.
// Depends on bist_pkg, bist_if, bist_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "bounded_integer_set_table_defines.svh"

module bounded_integer_set_table import bist_pkg::*; #(
   parameter int CAPACITY = BIST_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   bist_req_if.sink   req_chan,
   bist_rsp_if.source rsp_chan
);

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LEVELS = $clog2(CAPACITY);
   localparam int WIDE_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   logic                      busy_ff, busy_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [KIND_W-1:0]         kind_ff;
   logic signed [VALUE_W-1:0] value_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_success_ff, rsp_success_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic [CNT_W-1:0]          rsp_count_ff;

   logic                      req_fire, done;
   bist_cap_type              cap;
   bist_upd_type              upd;

   logic signed [VALUE_W-1:0] cell_data [CAPACITY];
   logic signed [VALUE_W-1:0] cell_rd   [CAPACITY];
   logic [CAPACITY-1:0]       match_vec, rsel_vec, shift_vec;
   logic                      hit, rhit, full;
   logic signed [VALUE_W-1:0] rdata;
   logic [WIDE_W-1:0]         count_wide;

   // One request in flight at a time
   assign req_chan.ready = !busy_ff;
   assign req_fire       = req_chan.valid && !busy_ff;
   assign done           = busy_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign cap.capture  = req_fire;
   assign cap.value    = req_chan.value;
   assign cap.position = req_chan.position;

   // Row of cells, each shifting from its upper neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] nxt;
      if (i == CAPACITY - 1) begin : g_last
         assign nxt = cell_data[i];
      end else begin : g_mid
         assign nxt = cell_data[i+1];
      end
      bist_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cap       (cap),
         .upd       (upd),
         .count     (count_ff),
         .shift_en  (shift_vec[i]),
         .next_data (nxt),
         .data      (cell_data[i]),
         .match     (match_vec[i]),
         .rsel      (rsel_vec[i]),
         .rd_gated  (cell_rd[i])
      );
   end

   // Mark every cell at or above the match for a shift-down
   always_comb begin
      logic [CAPACITY-1:0] p;
      p = match_vec;
      for (int k = 0; k < LEVELS; k++) begin
         p = p | (p << (1 << k));
      end
      shift_vec = p;
   end

   // Gather the selected entry for a read
   always_comb begin
      logic signed [VALUE_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         acc = acc | cell_rd[i];
      end
      rdata = acc;
   end

   assign hit  = |match_vec;
   assign rhit = |rsel_vec;
   assign full = count_ff == CNT_W'(CAPACITY);

   // Decide the outcome and the table update on commit
   always_comb begin
      upd.ins        = 1'b0;
      upd.rem        = 1'b0;
      upd.value      = value_ff;
      count_in       = count_ff;
      rsp_success_in = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_rdata_in   = '0;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (hit) begin
               rsp_status_in = ST_PRESENT;
            end else if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               upd.ins        = done;
               count_in       = count_ff + CNT_W'(1);
               rsp_success_in = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (hit) begin
               upd.rem        = done;
               count_in       = count_ff - CNT_W'(1);
               rsp_success_in = 1'b1;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         KIND_CONTAINS: begin
            if (hit) begin
               rsp_success_in = 1'b1;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         KIND_READ: begin
            if (rhit) begin
               rsp_success_in = 1'b1;
               rsp_rdata_in   = rdata;
            end else begin
               rsp_status_in = ST_RANGE;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   // Busy flag and response valid
   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (done) begin
            count_ff <= count_in;
         end
      end
   end

   // Hold the request and the response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= req_chan.kind;
         value_ff <= req_chan.value;
      end
      if (done) begin
         rsp_success_ff <= rsp_success_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_rdata_ff   <= rsp_rdata_in;
         rsp_count_ff   <= count_in;
      end
   end

   assign count_wide          = WIDE_W'(rsp_count_ff);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.success    = rsp_success_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_rdata_ff;
   assign rsp_chan.count      = count_wide[COUNT_W-1:0];
   assign rsp_chan.empty_res  = rsp_count_ff == '0;

   `BIST_ASSERT_IMP(a_match_unique, busy_ff, $onehot0(match_vec), "duplicate entries matched")
   `BIST_ASSERT_IMP(a_rsel_unique, busy_ff, $onehot0(rsel_vec), "several cells selected")
   `BIST_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "count past capacity")
   `BIST_ASSERT_NXT(a_insert_grows, done && upd.ins,
                    count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow count")
   `BIST_ASSERT_IMP(a_rsp_after_busy, $rose(rsp_valid_ff), $past(busy_ff),
                    "response without a request in flight")

endmodule
